// ----- hdl/trht_pkg.sv -----
// Shared types and constants of the touch region hit test block.
`timescale 1ns / 1ps

package trht_pkg;

  // Input item field widths
  localparam int unsigned RX_W    = 10;
  localparam int unsigned RY_W    = 9;
  localparam int unsigned RW_W    = 10;
  localparam int unsigned RH_W    = 9;
  localparam int unsigned ETYPE_W = 5;
  localparam int unsigned ECODE_W = 10;
  localparam int unsigned EVAL_W  = 12;

  // Result item field widths
  localparam int unsigned IDX_OUT_W = 7;
  localparam int unsigned COORD_W   = 12;

  // Stored region entry: {height, width, y, x}
  localparam int unsigned ENTRY_W = RX_W + RY_W + RW_W + RH_W;

  // Packed stream widths
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 40;

  // Item kinds carried on tuser
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_EVENT = 1'b1;

  // Event types and codes
  localparam logic [ETYPE_W-1:0] EVT_ABS    = 5'd3;
  localparam logic [ETYPE_W-1:0] EVT_KEY    = 5'd1;
  localparam logic [ECODE_W-1:0] CODE_X     = 10'd0;
  localparam logic [ECODE_W-1:0] CODE_Y     = 10'd1;
  localparam logic [ECODE_W-1:0] CODE_TOUCH = 10'd330;

  // X scale 10/13: floor(n/13) = (n * 80660) >> 20 for n below 2^18
  localparam logic [16:0] SCALE_X_MUL   = 17'd80660;
  localparam int unsigned SCALE_X_SHIFT = 20;
  // Y scale 4/5: floor(n/5) = (n * 13108) >> 16 for n below 2^14
  localparam logic [13:0] SCALE_Y_MUL   = 14'd13108;
  localparam int unsigned SCALE_Y_SHIFT = 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;     // latch the accepted item
    logic add_write;   // append the held region
    logic overflow_set;
    logic x_load;
    logic y_load;
    logic scan_start;  // load scan pointer from count
    logic scan_step;   // issue one table read, advance pointer
    logic res_latch;   // keep scan outcome
    logic out_load;    // move outcome into output register
  } trht_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_add;
    logic is_x;
    logic is_y;
    logic is_release;
    logic full;
    logic match;
    logic scan_end;
    logic out_free;
  } trht_sts_t;

endpackage

// ----- hdl/touch_region_hit_test_core.sv -----
// Top level of the touch region hit test block.
`timescale 1ns / 1ps
// Usage:
//   s_axis carries one item per handshake. tuser selects the kind: 0 appends a
//   region (x, y, width, height), 1 is an input event (type, code, value).
//   An X or Y axis event stores the scaled point; a touch release scans the
//   region table and gives one result item on m_axis; other items give none.
//   An add or axis event is decoded before the next item is accepted. A release
//   reaches the output register after the scan, which reads the table through
//   its single read port, one entry per cycle, from the top.
//   The scan stops at the first region that holds the point.
//   Reset clears the region count, the stored point and the overflow flag;
//   table entries need no clearing, so no item is blocked after reset.
//   When m_axis stalls, the finished result waits in the output register and
//   the next item is still taken; a following release waits for that
//   register to free before its result is loaded.
module touch_region_hit_test_core #(
  parameter int unsigned REGION_SLOTS = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [9:0] region_x, [18:10] region_y, [28:19] region_width,
  // [37:29] region_height, [42:38] event_type, [52:43] event_code,
  // [64:53] event_value, [71:65] zero
  input  logic [trht_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] cmd
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] hit, [7:1] region_index, [19:8] touch_x, [31:20] touch_y,
  // [32] table_overflow, [39:33] zero
  output logic [trht_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import trht_pkg::*;

  trht_cmd_t cmd;
  trht_sts_t sts;

  // Sequence the items
  trht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the table, scan it and drive the result
  trht_dp #(
    .REGION_SLOTS (REGION_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_user   (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// ----- hdl/trht_ctrl.sv -----
// Controller state machine of the touch region hit test block.
`timescale 1ns / 1ps

module trht_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  trht_pkg::trht_sts_t sts,
  output trht_pkg::trht_cmd_t cmd
);
  import trht_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Take no item while reset is held
  assign in_ready = (state == ST_IDLE) && !rst;

  // Sequence one item at a time
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_IDLE;
        priority if (sts.is_add) begin
          cmd.add_write    = !sts.full;
          cmd.overflow_set = sts.full;
        end else if (sts.is_x) begin
          cmd.x_load = 1'b1;
        end else if (sts.is_y) begin
          cmd.y_load = 1'b1;
        end else if (sts.is_release) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end else begin
          // drop any other event
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // stop on the first match walking down from the top entry
        if (sts.match || sts.scan_end) begin
          cmd.res_latch = 1'b1;
          state_next    = ST_RESULT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over an untaken item");

  a_capture_handshake: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (in_valid && in_ready))
    else $error("item captured without a handshake");

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.add_write, cmd.overflow_set, cmd.x_load, cmd.y_load, cmd.scan_start}))
    else $error("more than one decode action at once");

endmodule

// ----- hdl/trht_dp.sv -----
// Datapath of the touch region hit test block: item hold, region table, scan, output.
`timescale 1ns / 1ps

module trht_dp #(
  parameter int unsigned REGION_SLOTS = 128
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  trht_pkg::trht_cmd_t                  cmd,
  output trht_pkg::trht_sts_t                  sts,
  input  logic                                 in_user,
  input  logic [trht_pkg::IN_DATA_W-1:0]       in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [trht_pkg::OUT_DATA_W-1:0]      out_data
);
  import trht_pkg::*;

  localparam int unsigned CW = $clog2(REGION_SLOTS + 1);
  localparam int unsigned IW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;

  // Held item
  logic               item_cmd;
  logic [RX_W-1:0]    item_x;
  logic [RY_W-1:0]    item_y;
  logic [RW_W-1:0]    item_w;
  logic [RH_W-1:0]    item_h;
  logic [ETYPE_W-1:0] item_type;
  logic [ECODE_W-1:0] item_code;
  logic [EVAL_W-1:0]  item_value;

  // Block state
  logic [CW-1:0]      count;
  logic [COORD_W-1:0] last_x;
  logic [COORD_W-1:0] last_y;
  logic               overflow_seen;

  // Region table
  logic [ENTRY_W-1:0] mem [REGION_SLOTS];

  // Scan pipeline
  logic [IW-1:0]      ptr;
  logic               ptr_live;
  logic               rd_valid;
  logic [IW-1:0]      rd_idx;
  logic [ENTRY_W-1:0] rd_data;

  // Scan outcome
  logic               res_hit;
  logic [IW-1:0]      res_idx;

  // Scaling products
  logic [15:0] x_num;
  logic [32:0] x_prod;
  logic [13:0] y_num;
  logic [27:0] y_prod;

  // Containment of the stored point in the entry just read
  logic [RX_W-1:0] e_x;
  logic [RY_W-1:0] e_y;
  logic [RW_W-1:0] e_w;
  logic [RH_W-1:0] e_h;
  logic [RX_W:0]   x_end;
  logic [RY_W:0]   y_end;
  logic            holds;

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_cmd   <= in_user;
      item_x     <= in_data[9:0];
      item_y     <= in_data[18:10];
      item_w     <= in_data[28:19];
      item_h     <= in_data[37:29];
      item_type  <= in_data[42:38];
      item_code  <= in_data[52:43];
      item_value <= in_data[64:53];
    end
  end

  // Decode the held item
  always_comb begin
    sts            = '0;
    sts.is_add     = (item_cmd == CMD_ADD);
    sts.is_x       = (item_cmd == CMD_EVENT) && (item_type == EVT_ABS) && (item_code == CODE_X);
    sts.is_y       = (item_cmd == CMD_EVENT) && (item_type == EVT_ABS) && (item_code == CODE_Y);
    sts.is_release = (item_cmd == CMD_EVENT) && (item_type == EVT_KEY)
                     && (item_code == CODE_TOUCH) && (item_value == '0);
    sts.full       = (count == CW'(REGION_SLOTS));
    sts.match      = rd_valid && holds;
    sts.scan_end   = !ptr_live && !rd_valid;
    sts.out_free   = !out_valid || out_ready;
  end

  // Scale raw axis readings: value*10 and value*4 by shift-add, then reciprocal multiply
  assign x_num  = {1'b0, item_value, 3'b000} + {3'b000, item_value, 1'b0};
  assign x_prod = {17'd0, x_num} * {16'd0, SCALE_X_MUL};
  assign y_num  = {item_value, 2'b00};
  assign y_prod = {14'd0, y_num} * {14'd0, SCALE_Y_MUL};

  // Update count, stored point and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      last_x        <= '0;
      last_y        <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cmd.add_write) begin
        count <= count + 1'b1;
      end
      if (cmd.overflow_set) begin
        overflow_seen <= 1'b1;
      end
      if (cmd.x_load) begin
        last_x <= x_prod[SCALE_X_SHIFT +: COORD_W];
      end
      if (cmd.y_load) begin
        last_y <= y_prod[SCALE_Y_SHIFT +: COORD_W];
      end
    end
  end

  // Append a region
  always_ff @(posedge clk) begin
    if (cmd.add_write) begin
      mem[count[IW-1:0]] <= {item_h, item_w, item_y, item_x};
    end
  end

  // Walk the table from the top entry down, one read per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_live <= 1'b0;
      rd_valid <= 1'b0;
    end else if (cmd.scan_start) begin
      ptr_live <= (count != '0);
      rd_valid <= 1'b0;
    end else if (cmd.scan_step) begin
      rd_valid <= ptr_live;
      if (ptr_live && (ptr == '0)) begin
        ptr_live <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      ptr <= IW'(count - 1'b1);
    end else if (cmd.scan_step && ptr_live) begin
      rd_data <= mem[ptr];
      rd_idx  <= ptr;
      ptr     <= ptr - 1'b1;
    end
  end

  // Strict containment, ends formed one bit wider
  assign e_x   = rd_data[9:0];
  assign e_y   = rd_data[18:10];
  assign e_w   = rd_data[28:19];
  assign e_h   = rd_data[37:29];
  assign x_end = {1'b0, e_x} + {1'b0, e_w};
  assign y_end = {1'b0, e_y} + {1'b0, e_h};
  assign holds = (last_x > COORD_W'(e_x)) && (last_x < COORD_W'(x_end))
              && (last_y > COORD_W'(e_y)) && (last_y < COORD_W'(y_end));

  // Keep the scan outcome
  always_ff @(posedge clk) begin
    if (cmd.res_latch) begin
      res_hit <= sts.match;
      res_idx <= sts.match ? rd_idx : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {7'd0, overflow_seen, last_y, last_x, IDX_OUT_W'(res_idx), res_hit};
    end
  end

  a_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(overflow_seen) && !$past(rst) |-> overflow_seen)
    else $error("overflow flag cleared without reset");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(REGION_SLOTS))
    else $error("region count beyond table size");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (CW'(rd_idx) < count))
    else $error("scan read an entry above the count");

endmodule
